>>> hw/rtl/sensor_gated_valve_timer_defines.svh
// assertion macros shared by the valve timer rtl
`ifndef SENSOR_GATED_VALVE_TIMER_DEFINES_SVH
`define SENSOR_GATED_VALVE_TIMER_DEFINES_SVH

// property checked on every clock edge outside reset
`define SGVT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the trigger
`define SGVT_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sgvt_pkg.sv
`default_nettype none

package sgvt_pkg;

	localparam int unsigned SAMPLE_COUNT = 10;
	localparam int unsigned SUM_W        = 14;
	localparam int unsigned CNT_W        = 4;
	localparam int unsigned LEVEL_W      = 10;
	localparam int unsigned PERIOD_W     = 16;
	localparam int unsigned TIME_W       = 32;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 32;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_FORCE = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_CLOSED_TIME   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMER_MODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESH  = 3'd4;

	localparam logic [TIME_W-1:0]   RST_CLOSED_TIME   = 32'd5000;
	localparam logic [TIME_W-1:0]   RST_OPEN_TIME     = 32'd2000;
	localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD = 16'd500;
	localparam logic [LEVEL_W-1:0]  RST_LEVEL_THRESH  = 10'd500;

	typedef struct packed {
		logic [1:0]         command;
		logic [TIME_W-1:0]  now_ms;
		logic [LEVEL_W-1:0] sensor_value;
		logic               force_open;
	} item_t;

	typedef struct packed {
		logic valve_on;
		logic is_running;
		logic is_overridden;
	} result_t;

	typedef struct packed {
		logic [TIME_W-1:0]   closed_time_ms;
		logic [TIME_W-1:0]   open_time_ms;
		logic                timer_mode;
		logic [PERIOD_W-1:0] sample_period_ms;
		logic [LEVEL_W-1:0]  level_threshold;
	} cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/sgvt_cfg_regs.sv
`default_nettype none

module sgvt_cfg_regs
	import sgvt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output      cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.closed_time_ms   <= RST_CLOSED_TIME;
			cfg_q.open_time_ms     <= RST_OPEN_TIME;
			cfg_q.timer_mode       <= 1'b0;
			cfg_q.sample_period_ms <= RST_SAMPLE_PERIOD;
			cfg_q.level_threshold  <= RST_LEVEL_THRESH;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CLOSED_TIME:   cfg_q.closed_time_ms   <= wr_data[TIME_W-1:0];
				REG_OPEN_TIME:     cfg_q.open_time_ms     <= wr_data[TIME_W-1:0];
				REG_TIMER_MODE:    cfg_q.timer_mode       <= wr_data[0];
				REG_SAMPLE_PERIOD: cfg_q.sample_period_ms <= wr_data[PERIOD_W-1:0];
				REG_LEVEL_THRESH:  cfg_q.level_threshold  <= wr_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/sgvt_core.sv
`default_nettype none

`include "sensor_gated_valve_timer_defines.svh"

module sgvt_core
	import sgvt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    upd,
	input  wire item_t   item,
	input  wire cfg_t    cfg,
	output      result_t result
);

	logic              valve_q, running_q, override_q;
	logic [TIME_W-1:0] change_q, sample_time_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              valve_d, running_d, override_d;
	logic [TIME_W-1:0] change_d, sample_time_d;
	logic [SUM_W-1:0]  sum_d;
	logic [CNT_W-1:0]  cnt_d;

	logic [TIME_W-1:0]  since_chg, since_smp;
	logic [SUM_W-1:0]   sum_inc;
	logic [CNT_W-1:0]   cnt_inc;
	logic [LEVEL_W:0]   thr_p1;
	logic [SUM_W:0]     open_level;
	logic               avg_above;

	assign since_chg = item.now_ms - change_q;
	assign since_smp = item.now_ms - sample_time_q;
	assign sum_inc   = sum_q + {{(SUM_W-LEVEL_W){1'b0}}, item.sensor_value};
	assign cnt_inc   = cnt_q + CNT_W'(1);
	// floor(sum / cnt) > thr  <=>  sum >= cnt * (thr + 1)
	assign thr_p1     = {1'b0, cfg.level_threshold} + (LEVEL_W+1)'(1);
	assign open_level = {{(SUM_W+1-CNT_W){1'b0}}, cnt_inc}
		* {{(SUM_W-LEVEL_W){1'b0}}, thr_p1};
	assign avg_above  = {1'b0, sum_inc} >= open_level;

	always_comb begin
		valve_d       = valve_q;
		running_d     = running_q;
		override_d    = override_q;
		change_d      = change_q;
		sample_time_d = sample_time_q;
		sum_d         = sum_q;
		cnt_d         = cnt_q;
		unique case (cmd_t'(item.command))
			CMD_TICK: begin
				if (running_q && !override_q) begin
					if (!valve_q) begin
						if (since_chg > cfg.closed_time_ms) begin
							if (cfg.timer_mode) begin
								valve_d  = 1'b1;
								change_d = item.now_ms;
							end else if (since_smp >
									{{(TIME_W-PERIOD_W){1'b0}}, cfg.sample_period_ms}) begin
								sample_time_d = item.now_ms;
								sum_d         = sum_inc;
								cnt_d         = cnt_inc;
								if (cnt_inc > CNT_W'(SAMPLE_COUNT)) begin
									if (avg_above) begin
										valve_d  = 1'b1;
										change_d = item.now_ms;
									end else begin
										sum_d = '0;
										cnt_d = '0;
									end
								end
							end
						end
					end else if (since_chg > cfg.open_time_ms) begin
						valve_d  = 1'b0;
						change_d = item.now_ms;
						sum_d    = '0;
						cnt_d    = '0;
					end
				end
			end
			CMD_START: begin
				running_d = 1'b1;
				sum_d     = '0;
				cnt_d     = '0;
			end
			CMD_STOP: running_d = 1'b0;
			CMD_FORCE: begin
				override_d = 1'b1;
				valve_d    = item.force_open;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valve_q       <= 1'b0;
			running_q     <= 1'b0;
			override_q    <= 1'b0;
			change_q      <= '0;
			sample_time_q <= '0;
			sum_q         <= '0;
			cnt_q         <= '0;
		end else if (upd) begin
			valve_q       <= valve_d;
			running_q     <= running_d;
			override_q    <= override_d;
			change_q      <= change_d;
			sample_time_q <= sample_time_d;
			sum_q         <= sum_d;
			cnt_q         <= cnt_d;
		end
	end

	assign result.valve_on      = valve_d;
	assign result.is_running    = running_d;
	assign result.is_overridden = override_d;

	`SGVT_ASSERT_NEXT(a_override_sticky, override_q, override_q, "override flag dropped")
	`SGVT_ASSERT(a_count_bound, cnt_q <= CNT_W'(SAMPLE_COUNT + 1), "sample count overran")
	`SGVT_ASSERT_NEXT(a_hold_without_upd, !upd,
		$stable({valve_q, running_q, override_q, cnt_q}), "state moved without an item")

endmodule

`default_nettype wire

>>> hw/rtl/sensor_gated_valve_timer.sv
// an item is registered in the input register, then its result in the output register
// throughput: one item per cycle while the result is not stalled, the state update fits
//   between the input register and the result register
// a stalled result holds the output register, item_stall rises when the input one fills too
// reset clears valid flags and core state, loads register defaults; cfg_ready is always high
`default_nettype none

`include "sensor_gated_valve_timer_defines.svh"

module sensor_gated_valve_timer
	import sgvt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output      logic                  item_stall,
	input  wire item_t                 item,
	output      logic                  result_valid,
	input  wire logic                  result_stall,
	output      result_t               result,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	result_t core_result;
	logic    adv;
	logic    upd;

	assign cfg_ready = 1'b1;

	sgvt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// output register free or being drained this cycle
	assign adv        = !valid_s2 || !result_stall;
	assign upd        = valid_s1 && adv;
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (upd) begin
			result_s2 <= core_result;
		end
	end

	sgvt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

	`SGVT_ASSERT(a_stall_needs_item, !item_stall || valid_s1, "stall raised with empty input stage")
	`SGVT_ASSERT_NEXT(a_stalled_item_kept, valid_s1 && !adv, valid_s1,
		"held item lost while output stalled")
	`SGVT_ASSERT_NEXT(a_upd_fills_output, upd, valid_s2, "processed item did not reach output")

endmodule

`default_nettype wire
